// ----- rtl/access_locality_analyzer_unit_assert.svh -----
// Assertion macros for the access locality analyzer.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef ACCESS_LOCALITY_ANALYZER_UNIT_ASSERT_SVH
`define ACCESS_LOCALITY_ANALYZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ALA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define ALA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ala_pkg.sv -----
`default_nettype none

package ala_pkg;

	// Fixed field widths
	localparam int OFFSET_W = 24;
	localparam int BUF_W    = 24;
	localparam int STRIDE_W = 24;
	localparam int SCORE_W  = 7;
	localparam int MISS_W   = 4;

	// Distance accumulator
	localparam int              SUM_W   = 40;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// Shared divider runs one quotient bit per cycle over the full sum width
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Scoring constants
	localparam logic [SCORE_W-1:0] SCORE_MAX    = 7'd100;
	localparam int                 WSET_LOG2    = 14;   // working set of 16384 bytes
	localparam int                 TMP_PROD_W   = WSET_LOG2 + SCORE_W;
	// Divide by ten as multiply by 205 then shift right by 11 (exact below 1029)
	localparam int                 DIV10_MUL    = 205;
	localparam int                 DIV10_SHIFT  = 11;
	localparam int                 DIV10_PROD_W = SCORE_W + 8;
	localparam logic [MISS_W-1:0]  MISS_MIN     = 4'd1;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic                last;
	} acc_t;

	typedef struct packed {
		logic [SCORE_W-1:0]  spatial_score;
		logic [SCORE_W-1:0]  temporal_score;
		logic [STRIDE_W-1:0] mean_stride;
		logic [MISS_W-1:0]   miss_estimate;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG_LD,
		ST_AVG,
		ST_TMP_LD,
		ST_TMP,
		ST_DONE
	} ala_state_t;

endpackage

`default_nettype wire

// ----- rtl/access_locality_analyzer_unit.sv -----
`default_nettype none

// Channel   Direction  Handshake             Payload
// acc       in         acc_valid/acc_stall   acc_t: offset, last
// res       out        res_valid/res_stall   res_t: scores, stride, miss
// cfg       in         cfg_wr_en             cfg_wr_data: buffer_bytes
//
// An access with last low leaves the sequencer idle, so the block stays ready.
// A last access runs two 40-step divisions on one shared restoring divider (average
// stride, bytes per access); the spatial penalty is a reciprocal multiplication.
// The result is registered once both divisions are done; acc_stall is high from the last
// access until then and stays high while a held result keeps the sequencer in its final state.
// Reset clears the accumulators, the sequencer and buffer_bytes.

`include "access_locality_analyzer_unit_assert.svh"

module access_locality_analyzer_unit
	import ala_pkg::*;
#(
	parameter int LINE_BYTES   = 64,
	parameter int MAX_ACCESSES = 65536,
	parameter int OFFSET_BITS  = 24
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              acc_valid,
	output logic                   acc_stall,
	input  wire acc_t              acc,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output res_t                   res,
	input  wire logic              cfg_wr_en,
	input  wire logic [BUF_W-1:0]  cfg_wr_data
);

	localparam int OFF_W = (OFFSET_BITS < OFFSET_W) ? OFFSET_BITS : OFFSET_W;
	localparam logic [OFFSET_W-1:0] OFF_MASK = OFFSET_W'((64'(1) << OFF_W) - 64'(1));
	localparam int CNT_W = $clog2(MAX_ACCESSES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ACCESSES);
	localparam int LB_W  = $clog2(LINE_BYTES);
	localparam int DV_W  = CNT_W;
	localparam int REM_W = DV_W + 1;
	// avg * 100 / LINE_BYTES as avg * (100 * ceil(2^SP_SHIFT / LINE_BYTES)) >> SP_SHIFT,
	// exact for every average below one line
	localparam int     SP_SHIFT  = 2 * LB_W + SCORE_W;
	localparam longint SP_RECIP  = ((longint'(1) << SP_SHIFT) + longint'(LINE_BYTES) - 1)
	                               / longint'(LINE_BYTES);
	localparam int     SP_MUL_W  = LB_W + SCORE_W + 9;
	localparam logic [SP_MUL_W-1:0] SP_MUL = SP_MUL_W'(SP_RECIP * longint'(SCORE_MAX));
	localparam int     SP_PROD_W = LB_W + SP_MUL_W;

	// Accumulator state
	logic [OFFSET_W-1:0] prev_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [BUF_W-1:0]    buffer_q;

	// Sequencer and shared divider
	ala_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  quo_q;
	logic [DV_W-1:0]   rem_q;
	logic [DV_W-1:0]   dvs_q;
	logic              div_load, div_run, step_last;
	logic [SUM_W-1:0]  ld_dividend;
	logic [DV_W-1:0]   ld_divisor;

	// Intermediate results
	logic [STRIDE_W-1:0] stride_q;
	logic [SCORE_W-1:0]  spatial_q;

	// Output register
	logic res_valid_q;
	res_t res_q;
	logic res_free;

	logic acc_fire;
	assign acc_fire  = acc_valid && !acc_stall;
	assign acc_stall = (state_q != ST_IDLE);
	assign res_free  = !res_valid_q || !res_stall;
	assign step_last = (step_q == STEP_W'(DIV_STEPS - 1));

	// Distance update for the incoming access
	logic [OFFSET_W-1:0] off_m, delta;
	logic [SUM_W:0]      sum_add;
	logic [SUM_W-1:0]    sum_nx;
	always_comb begin
		off_m   = acc.offset & OFF_MASK;
		delta   = (off_m >= prev_q) ? (off_m - prev_q) : (prev_q - off_m);
		sum_add = {1'b0, sum_q} + (SUM_W+1)'(delta);
		sum_nx  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
	end

	// Spatial penalty from the average in quo_q, valid only when below one line
	logic                 avg_ge;
	logic [SP_PROD_W-1:0] sp_prod;
	logic [SCORE_W-1:0]   sp_pen;
	assign avg_ge  = (quo_q >= SUM_W'(LINE_BYTES));
	assign sp_prod = SP_PROD_W'(quo_q[LB_W-1:0]) * SP_PROD_W'(SP_MUL);
	assign sp_pen  = sp_prod[SP_SHIFT +: SCORE_W];

	// Temporal score from bytes per access left in quo_q
	logic                  rep_ge;
	logic [TMP_PROD_W-1:0] tmp_prod;
	logic [SCORE_W-1:0]    temporal;
	always_comb begin
		rep_ge   = |quo_q[SUM_W-1:WSET_LOG2];
		tmp_prod = TMP_PROD_W'(quo_q[WSET_LOG2-1:0]) * TMP_PROD_W'(SCORE_MAX);
		temporal = rep_ge ? '0 : (SCORE_MAX - tmp_prod[TMP_PROD_W-1:WSET_LOG2]);
	end

	// Miss estimate: (100 - spatial) / 10, at least one
	logic [SCORE_W-1:0]      miss_base;
	logic [DIV10_PROD_W-1:0] miss_prod;
	logic [MISS_W-1:0]       miss_raw, miss;
	always_comb begin
		miss_base = SCORE_MAX - spatial_q;
		miss_prod = DIV10_PROD_W'(miss_base) * DIV10_PROD_W'(DIV10_MUL);
		miss_raw  = miss_prod[DIV10_SHIFT +: MISS_W];
		miss      = (miss_raw < MISS_MIN) ? MISS_MIN : miss_raw;
	end

	// Sequencer next state and divider operand select
	always_comb begin
		state_d     = state_q;
		div_load    = 1'b0;
		div_run     = 1'b0;
		ld_dividend = '0;
		ld_divisor  = DV_W'(1);
		unique case (state_q)
			ST_IDLE: begin
				if (acc_fire && acc.last) begin
					state_d = ST_AVG_LD;
				end
			end
			ST_AVG_LD: begin
				// single access: divide zero by one
				div_load = 1'b1;
				if (cnt_q > CNT_W'(1)) begin
					ld_dividend = sum_q;
					ld_divisor  = DV_W'(cnt_q - CNT_W'(1));
				end
				state_d = ST_AVG;
			end
			ST_AVG: begin
				div_run = 1'b1;
				if (step_last) begin
					state_d = ST_TMP_LD;
				end
			end
			ST_TMP_LD: begin
				div_load    = 1'b1;
				ld_dividend = SUM_W'(buffer_q);
				ld_divisor  = DV_W'(cnt_q);
				state_d     = ST_TMP;
			end
			ST_TMP: begin
				div_run = 1'b1;
				if (step_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_q <= '0;
		end else if (cfg_wr_en) begin
			buffer_q <= cfg_wr_data;
		end
	end

	// Accumulators: updated per access, cleared when the result is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else if (acc_fire) begin
			prev_q <= off_m;
			if (cnt_q != '0) begin
				sum_q <= sum_nx;
			end
			if (cnt_q < CNT_MAX) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end else if (state_q == ST_DONE && res_free) begin
			prev_q <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end
	end

	// Shared restoring divider: one quotient bit per cycle
	logic [REM_W-1:0] trial;
	logic             trial_ge;
	always_comb begin
		trial    = {rem_q, quo_q[SUM_W-1]};
		trial_ge = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (div_load) begin
			step_q <= '0;
		end else if (div_run) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			quo_q <= ld_dividend;
			rem_q <= '0;
			dvs_q <= ld_divisor;
		end else if (div_run) begin
			quo_q <= {quo_q[SUM_W-2:0], trial_ge};
			rem_q <= trial_ge ? DV_W'(trial - {1'b0, dvs_q}) : trial[DV_W-1:0];
		end
	end

	// Stride and spatial score taken from the average before the second division
	always_ff @(posedge clk) begin
		if (state_q == ST_TMP_LD) begin
			stride_q  <= (|quo_q[SUM_W-1:STRIDE_W]) ? '1 : quo_q[STRIDE_W-1:0];
			spatial_q <= avg_ge ? '0 : (SCORE_MAX - sp_pen);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && res_free) begin
			res_q.spatial_score  <= spatial_q;
			res_q.temporal_score <= temporal;
			res_q.mean_stride    <= stride_q;
			res_q.miss_estimate  <= miss;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Assertions
	`ALA_ASSERT_SAME(a_res_from_done, $rose(res_valid_q), $past(state_q == ST_DONE), "result without finished sequence")
	`ALA_ASSERT_NEXT(a_plain_acc_one_cycle, acc_fire && !acc.last, state_q == ST_IDLE, "non-last access left sequencer busy")
	`ALA_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CNT_MAX, "access count beyond saturation")
	`ALA_ASSERT_SAME(a_res_range, res_valid_q, (res_q.spatial_score <= SCORE_MAX) && (res_q.temporal_score <= SCORE_MAX) && (res_q.miss_estimate >= MISS_MIN) && (res_q.miss_estimate <= 4'd10), "result field out of range")

endmodule

`default_nettype wire
